FILE: hw/rtl/sha256_pkg.sv
// Package for the SHA-256 byte stream hasher.
// Holds round constants, initial hash values and stream field widths.
// No dependencies.
package sha256_pkg;

	localparam int unsigned WordW     = 32;
	localparam int unsigned BlockW    = 512;
	localparam int unsigned Rounds    = 64;
	localparam int unsigned HashWords = 8;
	localparam int unsigned IdxW      = 3;
	localparam int unsigned OutDataW  = 40;

	localparam logic [IdxW-1:0] LastIdx = 3'd7;
	localparam logic [5:0]      LenPos  = 6'd56;
	localparam logic [7:0]      PadMark = 8'h80;

	localparam logic [WordW-1:0] K_TABLE [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [WordW-1:0] IV_TABLE [HashWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

endpackage

FILE: hw/rtl/sha256_byte_stream_hasher_top.sv
// SHA-256 byte stream hasher, top level.
// Depends on sha256_pkg for round constants and initial hash values.
//
// Each data request (tuser 0) shifts one byte into the 512-bit block
// register; the 64th byte of a block starts a compression, done by one
// shared round unit doing one round per cycle, followed by the final hash
// addition. A finish request (tuser 1) pads one byte per cycle up to the
// end of the block and runs one compression; when more than 55 bytes were
// pending, a second block of padding and a second compression follow. The
// eight digest words are then presented, index 0 first, tlast on index 7.
// The input is not ready while a block compresses, nor from a finish request
// until the last digest word is taken.
module sha256_byte_stream_hasher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tuser,  // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
	output logic        m_axis_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_HADD,
		ST_EMIT
	} state_t;

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic [63:0] msg_bits_q;
	logic        pad_q;
	logic        first_q;
	logic        len_ok_q;
	logic        emit_next_q;
	logic [31:0] hash_q [sha256_pkg::HashWords];
	logic [31:0] v_q [sha256_pkg::HashWords];
	logic [sha256_pkg::BlockW-1:0] blk_q;

	logic        ins_en;
	logic [7:0]  ins_byte;
	logic        len_sel;
	logic        wrap;
	logic [31:0] w_cur;
	logic [31:0] w_new;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch_v;
	logic [31:0] maj_v;

	assign len_sel = len_ok_q && (fill_q >= sha256_pkg::LenPos);

	always_comb begin
		ins_en   = 1'b0;
		ins_byte = s_axis_tdata;
		case (state_q)
			ST_IDLE: begin
				ins_en = s_axis_tvalid && !s_axis_tuser;
			end
			ST_PAD: begin
				ins_en = 1'b1;
				if (first_q) begin
					ins_byte = sha256_pkg::PadMark;
				end else if (len_sel) begin
					ins_byte = msg_bits_q[63:56];
				end else begin
					ins_byte = 8'd0;
				end
			end
			default: begin
				ins_en = 1'b0;
			end
		endcase
	end

	assign wrap = ins_en && (&fill_q);

	// Message schedule: window word 0 is the current W, slide in the next one.
	assign w_cur = blk_q[511:480];
	assign w_new = ssig1(blk_q[63:32]) + blk_q[223:192] + ssig0(blk_q[479:448]) + w_cur;

	assign ch_v  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj_v = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1    = v_q[7] + bsig1(v_q[4]) + ch_v + sha256_pkg::K_TABLE[rnd_q] + w_cur;
	assign t2    = bsig0(v_q[0]) + maj_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			rnd_q       <= '0;
			idx_q       <= '0;
			msg_bits_q  <= '0;
			pad_q       <= 1'b0;
			first_q     <= 1'b0;
			len_ok_q    <= 1'b0;
			emit_next_q <= 1'b0;
			for (int i = 0; i < sha256_pkg::HashWords; i++) begin
				hash_q[i] <= sha256_pkg::IV_TABLE[i];
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						if (s_axis_tuser) begin
							state_q  <= ST_PAD;
							pad_q    <= 1'b1;
							first_q  <= 1'b1;
							len_ok_q <= (fill_q < sha256_pkg::LenPos);
						end else begin
							msg_bits_q <= msg_bits_q + 64'd8;
						end
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					if (!first_q && len_sel) begin
						msg_bits_q <= {msg_bits_q[55:0], 8'd0};
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (&rnd_q) begin
						state_q <= ST_HADD;
					end
				end
				ST_HADD: begin
					for (int i = 0; i < sha256_pkg::HashWords; i++) begin
						hash_q[i] <= hash_q[i] + v_q[i];
					end
					if (emit_next_q) begin
						state_q <= ST_EMIT;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (m_axis_tready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == sha256_pkg::LastIdx) begin
							state_q     <= ST_IDLE;
							pad_q       <= 1'b0;
							emit_next_q <= 1'b0;
							for (int i = 0; i < sha256_pkg::HashWords; i++) begin
								hash_q[i] <= sha256_pkg::IV_TABLE[i];
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (ins_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (wrap) begin
				state_q     <= ST_ROUND;
				rnd_q       <= '0;
				emit_next_q <= pad_q && len_ok_q;
				if (pad_q) begin
					len_ok_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ins_en) begin
			blk_q <= {blk_q[503:0], ins_byte};
		end else if (state_q == ST_ROUND) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (wrap) begin
			v_q <= hash_q;
		end else if (state_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_EMIT);
	assign m_axis_tdata  = {5'd0, idx_q, hash_q[idx_q]};
	assign m_axis_tlast  = (idx_q == sha256_pkg::LastIdx);

endmodule

FILE: hw/rtl/sha256_chk.sv
// Port checker for the SHA-256 byte stream hasher, bound to the top level.
// Depends on sha256_pkg for the last digest word index.
module sha256_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	a_busy_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready while digest is pending");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled digest word changed");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[34:32] == sha256_pkg::LastIdx)))
		else $error("tlast does not match last word index");

	a_advance_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
		m_axis_tvalid && (m_axis_tdata[34:32] == $past(m_axis_tdata[34:32]) + 3'd1))
		else $error("digest words not contiguous");

endmodule

bind sha256_byte_stream_hasher_top sha256_chk u_sha256_chk (.*);
